// ===== rtl/bw_pkg.sv =====
// ----------------------------------------------------------------------------
// bw_pkg
// Shared widths, payload structs and inter-stage types for the barycentric
// weight pipeline.
// ----------------------------------------------------------------------------
package bw_pkg;

    localparam int COORD_BITS         = 16;
    localparam int WEIGHT_BITS        = 32;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int DIFF_BITS          = COORD_BITS + 1;
    localparam int DOT_BITS           = 2 * DIFF_BITS + 2;
    localparam int AREA_BITS          = 2 * DOT_BITS + 1;
    localparam int HALF_BITS          = (DOT_BITS + 1) / 2;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [DOT_BITS-1:0]    dot_t;
    typedef logic signed [AREA_BITS-1:0]   area_t;

    typedef struct packed {
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } bw_in_t;

    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        weight_t weight_c;
        logic    degenerate;
    } bw_out_t;

    typedef struct packed {
        dot_t ab_ab;
        dot_t ab_ac;
        dot_t ac_ac;
        dot_t at_ab;
        dot_t at_ac;
    } bw_dots_t;

    typedef struct packed {
        area_t abc;
        area_t atc;
        area_t abt;
    } bw_areas_t;

    // lane 0: atc / abc (weight c), lane 1: abt / abc (weight b)
    typedef struct packed {
        logic [1:0]                  neg;
        logic [1:0]                  over;
        logic [1:0][WEIGHT_BITS-1:0] mag;
        logic                        zero;
    } bw_quot_t;

endpackage

// ===== rtl/bw_dot.sv =====
// ----------------------------------------------------------------------------
// bw_dot
// Edge vectors and the five dot products, three register stages.
// ----------------------------------------------------------------------------
module bw_dot (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  bw_pkg::bw_in_t   in_data,
    output logic             out_valid,
    output bw_pkg::bw_dots_t out_dots
);
    import bw_pkg::*;

    localparam int PROD_BITS = 2 * DIFF_BITS;

    logic signed [DIFF_BITS-1:0] ab_reg [3];
    logic signed [DIFF_BITS-1:0] ac_reg [3];
    logic signed [DIFF_BITS-1:0] at_reg [3];
    logic signed [DIFF_BITS-1:0] a_next [3];
    logic signed [DIFF_BITS-1:0] b_next [3];
    logic signed [DIFF_BITS-1:0] c_next [3];
    logic signed [DIFF_BITS-1:0] t_next [3];
    logic signed [PROD_BITS-1:0] prod_reg [5][3];
    bw_dots_t                    dots_reg;
    logic [2:0]                  v_reg;

    always_comb begin
        a_next[0] = DIFF_BITS'(in_data.corner_a_x);
        a_next[1] = DIFF_BITS'(in_data.corner_a_y);
        a_next[2] = DIFF_BITS'(in_data.corner_a_z);
        b_next[0] = DIFF_BITS'(in_data.corner_b_x);
        b_next[1] = DIFF_BITS'(in_data.corner_b_y);
        b_next[2] = DIFF_BITS'(in_data.corner_b_z);
        c_next[0] = DIFF_BITS'(in_data.corner_c_x);
        c_next[1] = DIFF_BITS'(in_data.corner_c_y);
        c_next[2] = DIFF_BITS'(in_data.corner_c_z);
        t_next[0] = DIFF_BITS'(in_data.point_x);
        t_next[1] = DIFF_BITS'(in_data.point_y);
        t_next[2] = DIFF_BITS'(in_data.point_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ab_reg[k]      <= b_next[k] - a_next[k];
                ac_reg[k]      <= c_next[k] - a_next[k];
                at_reg[k]      <= t_next[k] - a_next[k];
                prod_reg[0][k] <= ab_reg[k] * ab_reg[k];
                prod_reg[1][k] <= ab_reg[k] * ac_reg[k];
                prod_reg[2][k] <= ac_reg[k] * ac_reg[k];
                prod_reg[3][k] <= at_reg[k] * ab_reg[k];
                prod_reg[4][k] <= at_reg[k] * ac_reg[k];
            end
            dots_reg.ab_ab <= DOT_BITS'(prod_reg[0][0]) + DOT_BITS'(prod_reg[0][1])
                              + DOT_BITS'(prod_reg[0][2]);
            dots_reg.ab_ac <= DOT_BITS'(prod_reg[1][0]) + DOT_BITS'(prod_reg[1][1])
                              + DOT_BITS'(prod_reg[1][2]);
            dots_reg.ac_ac <= DOT_BITS'(prod_reg[2][0]) + DOT_BITS'(prod_reg[2][1])
                              + DOT_BITS'(prod_reg[2][2]);
            dots_reg.at_ab <= DOT_BITS'(prod_reg[3][0]) + DOT_BITS'(prod_reg[3][1])
                              + DOT_BITS'(prod_reg[3][2]);
            dots_reg.at_ac <= DOT_BITS'(prod_reg[4][0]) + DOT_BITS'(prod_reg[4][1])
                              + DOT_BITS'(prod_reg[4][2]);
        end
    end

    assign out_valid = v_reg[2];
    assign out_dots  = dots_reg;

endmodule

// ===== rtl/bw_area.sv =====
// ----------------------------------------------------------------------------
// bw_area
// Squared-area terms abc, atc, abt. Each wide product is split into two
// half-width partial products, then summed, then the differences formed.
// ----------------------------------------------------------------------------
module bw_area (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  bw_pkg::bw_dots_t  in_dots,
    output logic              out_valid,
    output bw_pkg::bw_areas_t out_areas
);
    import bw_pkg::*;

    localparam int LO_BITS   = DOT_BITS + HALF_BITS + 1;
    localparam int HI_BITS   = 2 * DOT_BITS - HALF_BITS;
    localparam int PROD_BITS = 2 * DOT_BITS;

    dot_t                        mp [6];
    dot_t                        mq [6];
    logic signed [LO_BITS-1:0]   lo_reg [6];
    logic signed [HI_BITS-1:0]   hi_reg [6];
    logic signed [PROD_BITS-1:0] full_reg [6];
    bw_areas_t                   areas_reg;
    logic [2:0]                  v_reg;

    always_comb begin
        mp[0] = in_dots.ab_ab; mq[0] = in_dots.ac_ac;
        mp[1] = in_dots.ab_ac; mq[1] = in_dots.ab_ac;
        mp[2] = in_dots.ab_ab; mq[2] = in_dots.at_ac;
        mp[3] = in_dots.ab_ac; mq[3] = in_dots.at_ab;
        mp[4] = in_dots.ac_ac; mq[4] = in_dots.at_ab;
        mp[5] = in_dots.ab_ac; mq[5] = in_dots.at_ac;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                lo_reg[k]   <= mp[k] * $signed({1'b0, mq[k][HALF_BITS-1:0]});
                hi_reg[k]   <= mp[k] * $signed(mq[k][DOT_BITS-1:HALF_BITS]);
                full_reg[k] <= $signed({hi_reg[k], {HALF_BITS{1'b0}}})
                               + PROD_BITS'(lo_reg[k]);
            end
            areas_reg.abc <= AREA_BITS'(full_reg[0]) - AREA_BITS'(full_reg[1]);
            areas_reg.atc <= AREA_BITS'(full_reg[2]) - AREA_BITS'(full_reg[3]);
            areas_reg.abt <= AREA_BITS'(full_reg[4]) - AREA_BITS'(full_reg[5]);
        end
    end

    assign out_valid = v_reg[2];
    assign out_areas = areas_reg;

endmodule

// ===== rtl/bw_div.sv =====
// ----------------------------------------------------------------------------
// bw_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with a
// shared denominator. Overflow of the 32-bit quotient is flagged up front.
// ----------------------------------------------------------------------------
module bw_div #(
    parameter int FRACTION_BITS = bw_pkg::FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  bw_pkg::bw_areas_t in_areas,
    output logic              out_valid,
    output bw_pkg::bw_quot_t  out_quot
);
    import bw_pkg::*;

    localparam int REM_BITS = AREA_BITS + 1;
    localparam int NUM_BITS = AREA_BITS + FRACTION_BITS;
    localparam int STEPS    = WEIGHT_BITS;

    logic [AREA_BITS-1:0]   num_abs_reg [2];
    logic [AREA_BITS-1:0]   den_abs_reg;
    logic [1:0]             neg0_reg;
    logic                   zero0_reg;
    logic [NUM_BITS-1:0]    shifted [2];

    logic [REM_BITS-1:0]    rem_reg  [STEPS+1][2];
    logic [WEIGHT_BITS-1:0] lq_reg   [STEPS+1][2];
    logic [AREA_BITS-1:0]   den_reg  [STEPS+1];
    logic [1:0]             neg_reg  [STEPS+1];
    logic [1:0]             over_reg [STEPS+1];
    logic                   zero_reg [STEPS+1];
    logic [STEPS+1:0]       v_reg;

    logic [REM_BITS-1:0]    trial [STEPS][2];
    logic [REM_BITS:0]      sub   [STEPS][2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            shifted[l] = {num_abs_reg[l], {FRACTION_BITS{1'b0}}};
        end
        for (int s = 0; s < STEPS; s++) begin
            for (int l = 0; l < 2; l++) begin
                trial[s][l] = {rem_reg[s][l][REM_BITS-2:0], lq_reg[s][l][WEIGHT_BITS-1]};
                sub[s][l]   = {1'b0, trial[s][l]} - (REM_BITS + 1)'(den_reg[s]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STEPS:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_abs_reg[0] <= in_areas.atc[AREA_BITS-1] ? AREA_BITS'(-in_areas.atc)
                                                        : AREA_BITS'(in_areas.atc);
            num_abs_reg[1] <= in_areas.abt[AREA_BITS-1] ? AREA_BITS'(-in_areas.abt)
                                                        : AREA_BITS'(in_areas.abt);
            den_abs_reg    <= in_areas.abc[AREA_BITS-1] ? AREA_BITS'(-in_areas.abc)
                                                        : AREA_BITS'(in_areas.abc);
            neg0_reg[0]    <= in_areas.atc[AREA_BITS-1] ^ in_areas.abc[AREA_BITS-1];
            neg0_reg[1]    <= in_areas.abt[AREA_BITS-1] ^ in_areas.abc[AREA_BITS-1];
            zero0_reg      <= (in_areas.abc == '0);

            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l]  <= REM_BITS'(shifted[l][NUM_BITS-1:WEIGHT_BITS]);
                lq_reg[0][l]   <= shifted[l][WEIGHT_BITS-1:0];
                over_reg[0][l] <= REM_BITS'(shifted[l][NUM_BITS-1:WEIGHT_BITS])
                                  >= REM_BITS'(den_abs_reg);
            end
            den_reg[0]  <= den_abs_reg;
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= zero0_reg;

            for (int s = 0; s < STEPS; s++) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[s+1][l] <= sub[s][l][REM_BITS] ? trial[s][l]
                                                           : sub[s][l][REM_BITS-1:0];
                    lq_reg[s+1][l]  <= {lq_reg[s][l][WEIGHT_BITS-2:0], ~sub[s][l][REM_BITS]};
                end
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                over_reg[s+1] <= over_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    assign out_valid       = v_reg[STEPS+1];
    assign out_quot.neg    = neg_reg[STEPS];
    assign out_quot.over   = over_reg[STEPS];
    assign out_quot.mag[0] = lq_reg[STEPS][0];
    assign out_quot.mag[1] = lq_reg[STEPS][1];
    assign out_quot.zero   = zero_reg[STEPS];

endmodule

// ===== rtl/triangle_barycentric_weights.sv =====
// ----------------------------------------------------------------------------
// triangle_barycentric_weights
// Throughput: one transaction per cycle; the whole pipeline stalls only
// while a result waits at the output register.
// Reset: synchronous, active low, clears all valid bits; no payload reset.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights #(
    parameter int FRACTION_BITS = bw_pkg::FRACTION_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bw_pkg::bw_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output bw_pkg::bw_out_t m_data
);
    import bw_pkg::*;

    localparam int SUM_BITS = WEIGHT_BITS + 2;

    logic      pipe_en;
    logic      dot_valid;
    bw_dots_t  dots;
    logic      area_valid;
    bw_areas_t areas;
    logic      quot_valid;
    bw_quot_t  quot;

    logic      t1_valid_reg;
    weight_t   wb_reg;
    weight_t   wc_reg;
    logic      zero_reg;
    logic signed [SUM_BITS-1:0] wa_sum;
    weight_t   wa_sat;

    logic      m_valid_reg;
    bw_out_t   m_data_reg;

    function automatic weight_t sat_quot(input logic neg, input logic over,
                                         input logic [WEIGHT_BITS-1:0] mag);
        weight_t r;
        if (over) begin
            r = neg ? {1'b1, {(WEIGHT_BITS-1){1'b0}}} : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end else if (neg) begin
            r = (mag[WEIGHT_BITS-1] && (mag[WEIGHT_BITS-2:0] != '0))
                ? {1'b1, {(WEIGHT_BITS-1){1'b0}}} : weight_t'(-mag);
        end else begin
            r = mag[WEIGHT_BITS-1] ? {1'b0, {(WEIGHT_BITS-1){1'b1}}} : weight_t'(mag);
        end
        return r;
    endfunction

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    bw_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (dot_valid),
        .out_dots  (dots)
    );

    bw_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (dot_valid),
        .in_dots   (dots),
        .out_valid (area_valid),
        .out_areas (areas)
    );

    bw_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (area_valid),
        .in_areas  (areas),
        .out_valid (quot_valid),
        .out_quot  (quot)
    );

    always_comb begin
        wa_sum = (SUM_BITS'(1) <<< FRACTION_BITS) - SUM_BITS'(wb_reg) - SUM_BITS'(wc_reg);
        if (wa_sum > $signed(SUM_BITS'({1'b0, {(WEIGHT_BITS-1){1'b1}}}))) begin
            wa_sat = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end else if (wa_sum < -(SUM_BITS'(1) <<< (WEIGHT_BITS-1))) begin
            wa_sat = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
        end else begin
            wa_sat = wa_sum[WEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (pipe_en) begin
            t1_valid_reg <= quot_valid;
            m_valid_reg  <= t1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            wc_reg   <= sat_quot(quot.neg[0], quot.over[0], quot.mag[0]);
            wb_reg   <= sat_quot(quot.neg[1], quot.over[1], quot.mag[1]);
            zero_reg <= quot.zero;
            if (zero_reg) begin
                m_data_reg <= '{weight_a: '0, weight_b: '0, weight_c: '0, degenerate: 1'b1};
            end else begin
                m_data_reg <= '{weight_a: wa_sat, weight_b: wb_reg, weight_c: wc_reg,
                                degenerate: 1'b0};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.weight_a == '0 && m_data.weight_b == '0 && m_data.weight_c == '0)
        else $error("degenerate result with nonzero weight");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(t1_valid_reg) && $stable(wb_reg) && $stable(wc_reg))
        else $error("pipeline stage moved during stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !t1_valid_reg)
        else $error("valid set after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");
`endif

endmodule
